// File: sv/image_rotate_90_clockwise_macros.svh
// assertion helpers shared by the rotator modules
`ifndef IMAGE_ROTATE_90_CLOCKWISE_MACROS_SVH
`define IMAGE_ROTATE_90_CLOCKWISE_MACROS_SVH

// same-cycle implication, checked outside reset
`define IMROT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("imrot check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define IMROT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("imrot check failed: next-cycle implication");

`endif

// File: sv/imrot_pkg.sv
`default_nettype none
package imrot_pkg;

   localparam int MAX_SIDE_DEFAULT = 64;
   localparam int PIXEL_W          = 32;
   localparam int SIDE_W           = 7;

   // per-word control travelling from the address generator to the pipeline
   typedef struct packed {
      logic valid;  // a complete previous frame sits in the read half
      logic last;   // final pixel of the frame
   } flags_type;

endpackage
`default_nettype wire

// File: sv/imrot_store.sv
`default_nettype none
module imrot_store #(
   parameter int ADDR_W = 13
) (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [ADDR_W-1:0]            wr_addr,
   input  wire logic [imrot_pkg::PIXEL_W-1:0] wr_data,
   input  wire logic                         rd_en,
   input  wire logic [ADDR_W-1:0]            rd_addr,
   output logic      [imrot_pkg::PIXEL_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [imrot_pkg::PIXEL_W-1:0] mem [DEPTH];
   logic [imrot_pkg::PIXEL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/imrot_ctrl.sv
`default_nettype none
`include "image_rotate_90_clockwise_macros.svh"
module imrot_ctrl #(
   parameter int MAX_SIDE = imrot_pkg::MAX_SIDE_DEFAULT,
   parameter int IDX_W    = 6,
   parameter int ADDR_W   = 2 * IDX_W + 1
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [imrot_pkg::SIDE_W-1:0] csr_wdata,
   input  wire logic                        step,
   output logic      [ADDR_W-1:0]           wr_addr,
   output logic      [ADDR_W-1:0]           rd_addr,
   output imrot_pkg::flags_type             flags
);

   localparam logic [8:0]       MAX_SIDE_9 = 9'(MAX_SIDE);
   localparam logic [IDX_W-1:0] NM1_RESET  = IDX_W'(MAX_SIDE - 1);

   logic [IDX_W-1:0] row_ff, row_in;
   logic [IDX_W-1:0] col_ff, col_in;
   logic [IDX_W-1:0] nm1_ff, nm1_in;
   logic             half_ff, half_in;
   logic             ready_ff, ready_in;
   logic             row_end;
   logic             last;

   assign row_end = (col_ff == nm1_ff);
   assign last    = row_end && (row_ff == nm1_ff);

   // clamp side to 1..max, keep side minus one
   always_comb begin
      if (csr_wdata == '0) begin
         nm1_in = '0;
      end else if ({2'b00, csr_wdata} > MAX_SIDE_9) begin
         nm1_in = NM1_RESET;
      end else begin
         nm1_in = IDX_W'(csr_wdata - 7'd1);
      end
   end

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      half_in  = half_ff;
      ready_in = ready_ff;
      if (csr_we) begin
         row_in   = '0;
         col_in   = '0;
         ready_in = 1'b0;
      end else if (step) begin
         if (last) begin
            row_in   = '0;
            col_in   = '0;
            half_in  = ~half_ff;
            ready_in = 1'b1;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         half_ff  <= 1'b0;
         ready_ff <= 1'b0;
         nm1_ff   <= NM1_RESET;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         half_ff  <= half_in;
         ready_ff <= ready_in;
         if (csr_we) begin
            nm1_ff <= nm1_in;
         end
      end
   end

   // result (r, c) comes from source (n-1-c, r) of the other half
   assign wr_addr     = {half_ff, row_ff, col_ff};
   assign rd_addr     = {~half_ff, nm1_ff - col_ff, row_ff};
   assign flags.valid = ready_ff;
   assign flags.last  = last;

   `IMROT_ASSERT_NOW(a_pos_in_frame, clock, reset, 1'b1,
                     (row_ff <= nm1_ff) && (col_ff <= nm1_ff))
   `IMROT_ASSERT_NEXT(a_frame_done_ready, clock, reset, step && last && !csr_we,
                      ready_ff && (half_ff != $past(half_ff)))

endmodule
`default_nettype wire

// File: sv/image_rotate_90_clockwise.sv
// quarter-turn clockwise rotator, ping-pong frame store of 2 x (2^IDX_W)^2 words
// an accepted word is read into the store register, then into the output register
// throughput: one word per cycle unless rsp_tready stalls, set by the 1W/1R store
// reset: counters, write half and frame-ready flag cleared, side length MAX_SIDE;
// store contents are not cleared and results read invalid until a frame completes
`default_nettype none
`include "image_rotate_90_clockwise_macros.svh"
module image_rotate_90_clockwise #(
   parameter int MAX_SIDE = imrot_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic [imrot_pkg::SIDE_W-1:0]  csr_wdata,   // side_length
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [imrot_pkg::PIXEL_W-1:0] req_tdata,   // pixel_in
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [imrot_pkg::PIXEL_W-1:0] rsp_tdata,   // pixel_out
   output logic                              rsp_tuser,   // out_valid
   output logic                              rsp_tlast    // frame_last
);

   localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int ADDR_W = 2 * IDX_W + 1;

   logic                          accept;
   logic [ADDR_W-1:0]             wr_addr;
   logic [ADDR_W-1:0]             rd_addr;
   imrot_pkg::flags_type          flags;
   logic [imrot_pkg::PIXEL_W-1:0] rd_data;

   logic                          s1_valid_ff, s1_valid_in;
   imrot_pkg::flags_type          s1_flags_ff;
   logic                          s1_adv;
   logic                          s2_valid_ff, s2_valid_in;
   logic [imrot_pkg::PIXEL_W-1:0] pix_ff;
   logic                          user_ff;
   logic                          last_ff;

   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   imrot_ctrl #(
      .MAX_SIDE (MAX_SIDE),
      .IDX_W    (IDX_W),
      .ADDR_W   (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .step      (accept),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .flags     (flags)
   );

   imrot_store #(
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign s1_valid_in = accept || (s1_valid_ff && !s1_adv);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= flags;
      end
      // invalid words carry zero data and no frame mark
      if (s1_adv) begin
         pix_ff  <= s1_flags_ff.valid ? rd_data : '0;
         user_ff <= s1_flags_ff.valid;
         last_ff <= s1_flags_ff.valid && s1_flags_ff.last;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = pix_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

   `IMROT_ASSERT_NOW(a_last_is_valid, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser)
   `IMROT_ASSERT_NOW(a_invalid_zero, clock, reset, rsp_tvalid && !rsp_tuser,
                     rsp_tdata == '0)
   `IMROT_ASSERT_NOW(a_stall_only_when_full, clock, reset, s1_valid_ff && !s1_adv,
                     s2_valid_ff && !rsp_tready)
   `IMROT_ASSERT_NEXT(a_accept_fills_s1, clock, reset, accept, s1_valid_ff)

endmodule
`default_nettype wire
